/* rtl/trcf_pkg.sv */
// ---------------------------------------------------------------------------
// Threshold run cluster finder package
// Shared field widths, register indexes and the closed-run record type.
// ---------------------------------------------------------------------------
package trcf_pkg;

   localparam int ADC_W        = 12;
   localparam int TIME_W       = 24;
   localparam int ENERGY_W     = 16;
   localparam int ADC_SUM_W    = 22;
   localparam int WT_W         = 47;
   localparam int ENERGY_SUM_W = 26;
   localparam int PROD_W       = 36;
   localparam int MINB_W       = 11;

   localparam int REQ_DATA_W   = 56;
   localparam int RSP_DATA_W   = 72;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_ADC_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BINS      = 1'd1;

   localparam logic [ADC_W-1:0]  THRESHOLD_RESET = 12'd10;
   localparam logic [MINB_W-1:0] MIN_BINS_RESET  = 11'd2;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // Numerator of the rounded centroid is 2*|wt| + sum, one quotient bit per step.
   localparam int NUM_W      = 48;
   localparam int DIV_STEPS  = 48;
   localparam int DIV_CNT_W  = 6;

   localparam logic [TIME_W-1:0] TIME_MAX = 24'h7F_FFFF;
   localparam logic [TIME_W-1:0] TIME_MIN = 24'h80_0000;

   typedef struct packed {
      logic [ADC_SUM_W-1:0]    adc_sum;
      logic [WT_W-1:0]         wt_sum;
      logic [ENERGY_SUM_W-1:0] energy_sum;
   } run_rec_type;

endpackage

/* rtl/trcf_front.sv */
// ---------------------------------------------------------------------------
// Run accumulator front end
// Registers each bin with its time-weighted product, then folds it into the
// open run and hands closed runs that are long enough to the cluster queue.
// ---------------------------------------------------------------------------
module trcf_front #(
   parameter int MAX_RUN_BINS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [trcf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [trcf_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [trcf_pkg::ADC_W-1:0]        req_adc,
   input  logic signed [trcf_pkg::TIME_W-1:0] req_time,
   input  logic [trcf_pkg::ENERGY_W-1:0]     req_energy,
   input  logic                              req_last,
   input  logic                              fifo_full,
   output logic                              push,
   output trcf_pkg::run_rec_type             push_rec
);
   import trcf_pkg::*;

   localparam int RL_W  = $clog2(MAX_RUN_BINS + 1);
   localparam int CMP_W = (RL_W > MINB_W) ? RL_W : MINB_W;
   localparam logic [RL_W-1:0] RL_MAX = RL_W'(MAX_RUN_BINS);

   logic [ADC_W-1:0]  threshold_ff;
   logic [MINB_W-1:0] min_bins_ff;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_hit_ff, s1_last_ff;
   logic [ADC_W-1:0]         s1_adc_ff;
   logic [ENERGY_W-1:0]      s1_energy_ff;
   logic signed [PROD_W-1:0] s1_prod_ff;
   logic signed [PROD_W:0]   prod_full;

   logic                    run_open_ff;
   logic [RL_W-1:0]         run_len_ff, len_after;
   logic [ADC_SUM_W-1:0]    adc_acc_ff, adc_after;
   logic [WT_W-1:0]         wt_acc_ff, wt_after;
   logic [ENERGY_SUM_W-1:0] energy_acc_ff, energy_after;

   logic [ADC_SUM_W:0]      adc_add;
   logic [ENERGY_SUM_W:0]   energy_add;
   logic signed [WT_W:0]    wt_add;
   logic [WT_W-1:0]         wt_sat;

   logic req_accept, close, emit, s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         min_bins_ff  <= MIN_BINS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ADC_THRESHOLD: threshold_ff <= csr_data;
            CSR_MIN_BINS:      min_bins_ff  <= csr_data[MINB_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready  = !s1_valid_ff || s1_adv;
   assign req_accept = req_valid && req_ready;
   assign prod_full  = req_time * $signed({1'b0, req_adc});

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_hit_ff    <= (req_adc >= threshold_ff);
         s1_last_ff   <= req_last;
         s1_adc_ff    <= req_adc;
         s1_energy_ff <= req_energy;
         s1_prod_ff   <= prod_full[PROD_W-1:0];
      end
   end

   // Saturating sums of the run including the registered bin.
   always_comb begin
      adc_add    = {1'b0, adc_acc_ff} + (ADC_SUM_W + 1)'(s1_adc_ff);
      energy_add = {1'b0, energy_acc_ff} + (ENERGY_SUM_W + 1)'(s1_energy_ff);
      wt_add     = $signed({wt_acc_ff[WT_W-1], wt_acc_ff}) + (WT_W + 1)'(s1_prod_ff);
      if (wt_add[WT_W] != wt_add[WT_W-1]) begin
         wt_sat = wt_add[WT_W] ? {1'b1, {(WT_W-1){1'b0}}} : {1'b0, {(WT_W-1){1'b1}}};
      end else begin
         wt_sat = wt_add[WT_W-1:0];
      end
      if (s1_hit_ff) begin
         len_after    = (run_len_ff < RL_MAX) ? run_len_ff + 1'b1 : run_len_ff;
         adc_after    = adc_add[ADC_SUM_W] ? '1 : adc_add[ADC_SUM_W-1:0];
         energy_after = energy_add[ENERGY_SUM_W] ? '1 : energy_add[ENERGY_SUM_W-1:0];
         wt_after     = wt_sat;
      end else begin
         len_after    = run_len_ff;
         adc_after    = adc_acc_ff;
         energy_after = energy_acc_ff;
         wt_after     = wt_acc_ff;
      end
   end

   // A hit closes the run only on the last bin; a miss closes any open run.
   assign close  = s1_hit_ff ? s1_last_ff : run_open_ff;
   assign emit   = close && (CMP_W'(len_after) >= CMP_W'(min_bins_ff));
   assign s1_adv = s1_valid_ff && !(emit && fifo_full);
   assign push   = s1_adv && emit;

   assign push_rec.adc_sum    = adc_after;
   assign push_rec.wt_sum     = wt_after;
   assign push_rec.energy_sum = energy_after;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff   <= 1'b0;
         run_len_ff    <= '0;
         adc_acc_ff    <= '0;
         wt_acc_ff     <= '0;
         energy_acc_ff <= '0;
      end else if (s1_adv) begin
         if (close) begin
            run_open_ff   <= 1'b0;
            run_len_ff    <= '0;
            adc_acc_ff    <= '0;
            wt_acc_ff     <= '0;
            energy_acc_ff <= '0;
         end else if (s1_hit_ff) begin
            run_open_ff   <= 1'b1;
            run_len_ff    <= len_after;
            adc_acc_ff    <= adc_after;
            wt_acc_ff     <= wt_after;
            energy_acc_ff <= energy_after;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_full)
      else $error("cluster pushed into a full queue");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      run_len_ff <= RL_MAX)
      else $error("run length above its saturation point");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && close) |=> (!run_open_ff && adc_acc_ff == '0 && run_len_ff == '0))
      else $error("run state not cleared after close");
`endif

endmodule

/* rtl/trcf_fifo.sv */
// ---------------------------------------------------------------------------
// Cluster queue
// Short register queue of closed runs between the accumulator and divider.
// ---------------------------------------------------------------------------
module trcf_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  trcf_pkg::run_rec_type push_rec,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output trcf_pkg::run_rec_type rd_rec
);
   import trcf_pkg::*;

   run_rec_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]     count_ff, count_in;

   assign full   = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign valid  = (count_ff != '0);
   assign rd_rec = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

/* rtl/trcf_back.sv */
// ---------------------------------------------------------------------------
// Centroid back end
// Takes one closed run at a time, divides the weighted time by the ADC sum
// with round-half-away rounding, clamps it and presents the cluster item.
// ---------------------------------------------------------------------------
module trcf_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  fifo_valid,
   input  trcf_pkg::run_rec_type                 fifo_rec,
   output logic                                  fifo_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [trcf_pkg::ADC_SUM_W-1:0]        rsp_adc_sum,
   output logic [trcf_pkg::TIME_W-1:0]           rsp_mean_time,
   output logic [trcf_pkg::ENERGY_SUM_W-1:0]     rsp_energy_sum
);
   import trcf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [WT_W-1:0]         mag_ff;
   logic [ADC_SUM_W-1:0]    sum_ff;
   logic                    neg_ff;
   logic [ENERGY_SUM_W-1:0] energy_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [ADC_SUM_W:0]      rem_ff;
   logic [DIV_CNT_W-1:0]    cnt_ff;

   logic                    rsp_valid_ff;
   logic [ADC_SUM_W-1:0]    rsp_adc_ff;
   logic [TIME_W-1:0]       rsp_time_ff;
   logic [ENERGY_SUM_W-1:0] rsp_energy_ff;

   logic [ADC_SUM_W:0]      divisor;
   logic [ADC_SUM_W+1:0]    rem_sh;
   logic [ADC_SUM_W+2:0]    diff;
   logic                    q_bit;
   logic                    q_big, over;
   logic [TIME_W-1:0]       time_res;
   logic                    rsp_load;

   assign divisor = {sum_ff, 1'b0};
   assign rem_sh  = {rem_ff, num_ff[NUM_W-1]};
   assign diff    = {1'b0, rem_sh} - {2'b00, divisor};
   assign q_bit   = !diff[ADC_SUM_W+2];

   assign fifo_pop = (state_ff == ST_IDLE) && fifo_valid;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Clamp the quotient magnitude to the signed time range.
   always_comb begin
      q_big = |num_ff[NUM_W-1:TIME_W];
      if (neg_ff) begin
         over     = q_big || (num_ff[TIME_W-1] && (|num_ff[TIME_W-2:0]));
         time_res = over ? TIME_MIN : (~num_ff[TIME_W-1:0] + 1'b1);
      end else begin
         over     = q_big || num_ff[TIME_W-1];
         time_res = over ? TIME_MAX : num_ff[TIME_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (fifo_valid) state_in = ST_PREP;
         ST_PREP: state_in = (sum_ff == '0) ? ST_DONE : ST_DIV;
         ST_DIV:  if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = ST_DONE;
         ST_DONE: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (fifo_valid) begin
               neg_ff    <= fifo_rec.wt_sum[WT_W-1];
               mag_ff    <= fifo_rec.wt_sum[WT_W-1] ? (~fifo_rec.wt_sum + 1'b1)
                                                    : fifo_rec.wt_sum;
               sum_ff    <= fifo_rec.adc_sum;
               energy_ff <= fifo_rec.energy_sum;
            end
         end
         ST_PREP: begin
            // A zero sum leaves a zero quotient, which reports time zero.
            num_ff <= (sum_ff == '0) ? '0 : ({mag_ff, 1'b0} + NUM_W'(sum_ff));
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         ST_DIV: begin
            rem_ff <= q_bit ? diff[ADC_SUM_W:0] : rem_sh[ADC_SUM_W:0];
            num_ff <= {num_ff[NUM_W-2:0], q_bit};
            cnt_ff <= cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_adc_ff    <= sum_ff;
         rsp_time_ff   <= time_res;
         rsp_energy_ff <= energy_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_adc_sum    = rsp_adc_ff;
   assign rsp_mean_time  = rsp_time_ff;
   assign rsp_energy_sum = rsp_energy_ff;

`ifndef NO_ASSERTIONS
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < divisor))
      else $error("divider remainder not below divisor");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff < DIV_CNT_W'(DIV_STEPS)))
      else $error("divider ran past its step count");

   a_pop_prep: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |=> (state_ff == ST_PREP))
      else $error("popped run not taken into preparation");
`endif

endmodule

/* rtl/threshold_run_cluster_finder.sv */
// ---------------------------------------------------------------------------
// Threshold run cluster finder
// Finds runs of bins at or above an ADC threshold and reports each long
// enough run as a cluster with ADC sum, ADC-weighted mean time and energy.
// ---------------------------------------------------------------------------
// Throughput: one bin per cycle; a bin is held back only when it closes an
// emitted run while the four-entry cluster queue is full.
// Path: a closing bin passes the bin register and the cluster queue, then the
// back end's prep, divide and done states; it takes one cluster at a time.
// Reset: synchronous; clears the open run, the queue and the output, and sets
// adc_threshold to 10 and min_bins to 2.
module threshold_run_cluster_finder #(
   parameter int MAX_RUN_BINS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // adc_value[11:0], bin_time[35:12], bin_energy[51:36], zero pad[55:52]
   input  logic [trcf_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // adc_sum[21:0], mean_time[45:22], energy_sum[71:46]
   output logic [trcf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [trcf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [trcf_pkg::CSR_DATA_W-1:0]     csr_data
);
   import trcf_pkg::*;

   logic                    fifo_full, fifo_valid, push, pop;
   run_rec_type             push_rec, rd_rec;
   logic [ADC_SUM_W-1:0]    rsp_adc_sum;
   logic [TIME_W-1:0]       rsp_mean_time;
   logic [ENERGY_SUM_W-1:0] rsp_energy_sum;

   assign csr_ready = 1'b1;

   trcf_front #(
      .MAX_RUN_BINS(MAX_RUN_BINS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_adc    (req_tdata[ADC_W-1:0]),
      .req_time   ($signed(req_tdata[ADC_W+TIME_W-1:ADC_W])),
      .req_energy (req_tdata[ADC_W+TIME_W+ENERGY_W-1:ADC_W+TIME_W]),
      .req_last   (req_tlast),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_rec   (push_rec)
   );

   trcf_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .full     (fifo_full),
      .pop      (pop),
      .valid    (fifo_valid),
      .rd_rec   (rd_rec)
   );

   trcf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_valid     (fifo_valid),
      .fifo_rec       (rd_rec),
      .fifo_pop       (pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_adc_sum    (rsp_adc_sum),
      .rsp_mean_time  (rsp_mean_time),
      .rsp_energy_sum (rsp_energy_sum)
   );

   assign rsp_tdata = {rsp_energy_sum, rsp_mean_time, rsp_adc_sum};

endmodule
